FILE: hw/rtl/mwf_pkg.sv
package mwf_pkg;

   // Operation codes carried by a request transaction.
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   // Status codes returned with every response transaction.
   localparam logic [2:0] STAT_OK          = 3'd0;
   localparam logic [2:0] STAT_BAD_COORD   = 3'd1;
   localparam logic [2:0] STAT_PLAYER_DUP  = 3'd2;
   localparam logic [2:0] STAT_START_DUP   = 3'd3;
   localparam logic [2:0] STAT_NOT_RUNNING = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] CSR_GRID_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_GRID_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_SPACE_CODE  = 3'd2;
   localparam logic [2:0] CSR_EXIT_CODE   = 3'd3;
   localparam logic [2:0] CSR_PLAYER_CODE = 3'd4;
   localparam logic [2:0] CSR_START_CODE  = 3'd5;

   // Headings, counted counterclockwise so that a left turn adds one.
   localparam logic [1:0] HEAD_RIGHT = 2'd0;
   localparam logic [1:0] HEAD_UP    = 2'd1;
   localparam logic [1:0] HEAD_LEFT  = 2'd2;
   localparam logic [1:0] HEAD_DOWN  = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [6:0] RST_GRID_WIDTH  = 7'd64;
   localparam logic [6:0] RST_GRID_HEIGHT = 7'd64;
   localparam logic [7:0] RST_SPACE_CODE  = 8'd5;
   localparam logic [7:0] RST_EXIT_CODE   = 8'd3;
   localparam logic [7:0] RST_PLAYER_CODE = 8'd1;
   localparam logic [7:0] RST_START_CODE  = 8'd2;

   // A neighbour coordinate with one guard bit. Stepping below zero wraps to a
   // value above any grid dimension, so one compare marks it as outside.
   typedef logic [6:0] coord_type;
   typedef logic [7:0] tile_type;

   // Column of the neighbour in the given heading.
   function automatic coord_type step_x(input logic [5:0] x, input logic [1:0] h);
      coord_type r;
      r = {1'b0, x};
      if (h == HEAD_RIGHT) begin
         r = r + 7'd1;
      end else if (h == HEAD_LEFT) begin
         r = r - 7'd1;
      end
      return r;
   endfunction

   // Row of the neighbour in the given heading.
   function automatic coord_type step_y(input logic [5:0] y, input logic [1:0] h);
      coord_type r;
      r = {1'b0, y};
      if (h == HEAD_UP) begin
         r = r - 7'd1;
      end else if (h == HEAD_DOWN) begin
         r = r + 7'd1;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/mwf_ram.sv
module mwf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one read port with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/maze_wall_follower_top.sv
// Channel  Direction  Handshake                Payload
// req      in         req_valid / req_ready    operation, cell_x, cell_y, tile
// rsp      out        rsp_valid / rsp_ready    status, walker column and row, heading,
//                                              moved, reached_exit, running
// csr      in         csr_we (no wait)         csr_index, csr_wdata
//
// Write and stop go straight to the response register; a tick reads the tile ahead,
// then the tile to the left; a start scans every cell of the grid in use, one store read a cycle.
// A tick is bound by the single read port of the tile store.
// After reset a clearing pass zeroes all min(GRID_COLS,64)*min(GRID_ROWS,64) cells
// of the store while req_ready stays low. A new transaction is accepted while
// the previous response waits; its last step holds until the output register frees.
module maze_wall_follower_top
   import mwf_pkg::*;
#(
   parameter int GRID_COLS = 64,
   parameter int GRID_ROWS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [5:0] req_cell_x,
   input  logic [5:0] req_cell_y,
   input  logic [7:0] req_tile,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [5:0] rsp_player_x,
   output logic [5:0] rsp_player_y,
   output logic [1:0] rsp_heading,
   output logic       rsp_moved,
   output logic       rsp_reached_exit,
   output logic       rsp_running,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   // Only the first 64 columns and rows can ever be addressed.
   localparam int MEM_COLS  = (GRID_COLS < 64) ? GRID_COLS : 64;
   localparam int MEM_ROWS  = (GRID_ROWS < 64) ? GRID_ROWS : 64;
   localparam int MEM_DEPTH = MEM_COLS * MEM_ROWS;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam logic [6:0] COLS_LIMIT = 7'(MEM_COLS);
   localparam logic [6:0] ROWS_LIMIT = 7'(MEM_ROWS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);

   // Sequencer states.
   localparam logic [3:0] S_CLEAR       = 4'd0;
   localparam logic [3:0] S_IDLE        = 4'd1;
   localparam logic [3:0] S_SCAN        = 4'd2;
   localparam logic [3:0] S_SCAN_LAST   = 4'd3;
   localparam logic [3:0] S_SCAN_FIN    = 4'd4;
   localparam logic [3:0] S_TICK_AHEAD  = 4'd5;
   localparam logic [3:0] S_TICK_LEFT   = 4'd6;
   localparam logic [3:0] S_TICK_DECIDE = 4'd7;
   localparam logic [3:0] S_TICK_MOVE   = 4'd8;
   localparam logic [3:0] S_RESP        = 4'd9;

   // Row-major address of a cell in the tile store.
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [5:0] x, input logic [5:0] y);
      return ADDR_W'(32'(y) * MEM_COLS + 32'(x));
   endfunction

   logic [3:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   logic [5:0] col_ff, col_in;
   logic [5:0] row_ff, row_in;
   logic [1:0] head_ff, head_in;
   logic       active_ff, active_in;

   logic [6:0] width_ff, width_in;
   logic [6:0] height_ff, height_in;
   tile_type   space_ff, space_in;
   tile_type   exit_ff, exit_in;
   tile_type   player_code_ff, player_code_in;
   tile_type   start_code_ff, start_code_in;

   logic [2:0] status_ff, status_in;
   logic       moved_ff, moved_in;
   logic       reached_ff, reached_in;

   logic [5:0] scan_x_ff, scan_x_in;
   logic [5:0] scan_y_ff, scan_y_in;
   logic       pend_valid_ff, pend_valid_in;
   logic [5:0] pend_x_ff, pend_x_in;
   logic [5:0] pend_y_ff, pend_y_in;
   logic [1:0] start_cnt_ff, start_cnt_in;
   logic [1:0] player_cnt_ff, player_cnt_in;
   logic [5:0] found_x_ff, found_x_in;
   logic [5:0] found_y_ff, found_y_in;
   tile_type   ahead_tile_ff, ahead_tile_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [5:0] rsp_x_ff, rsp_x_in;
   logic [5:0] rsp_y_ff, rsp_y_in;
   logic [1:0] rsp_head_ff, rsp_head_in;
   logic       rsp_moved_ff, rsp_moved_in;
   logic       rsp_reached_ff, rsp_reached_in;
   logic       rsp_running_ff, rsp_running_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   tile_type          mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;
   tile_type          mem_rdata;

   logic [6:0] cols_used;
   logic [6:0] rows_used;
   logic [1:0] left_head;
   coord_type  ahead_x, ahead_y, left_x, left_y;
   logic       ahead_in, left_in, old_in_store;

   mwf_ram #(
      .WIDTH(8),
      .DEPTH(MEM_DEPTH)
   ) u_tile_store (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   // Grid dimensions in use, clamped to one and to the store size.
   always_comb begin
      priority if (width_ff == 7'd0) begin
         cols_used = 7'd1;
      end else if (width_ff > COLS_LIMIT) begin
         cols_used = COLS_LIMIT;
      end else begin
         cols_used = width_ff;
      end
      priority if (height_ff == 7'd0) begin
         rows_used = 7'd1;
      end else if (height_ff > ROWS_LIMIT) begin
         rows_used = ROWS_LIMIT;
      end else begin
         rows_used = height_ff;
      end
   end

   // Neighbours of the walker and whether they lie inside the grid in use.
   always_comb begin
      left_head    = head_ff + 2'd1;
      ahead_x      = step_x(col_ff, head_ff);
      ahead_y      = step_y(row_ff, head_ff);
      left_x       = step_x(col_ff, left_head);
      left_y       = step_y(row_ff, left_head);
      ahead_in     = (ahead_x < cols_used) && (ahead_y < rows_used);
      left_in      = (left_x < cols_used) && (left_y < rows_used);
      old_in_store = ({1'b0, col_ff} < COLS_LIMIT) && ({1'b0, row_ff} < ROWS_LIMIT);
   end

   // Next-state logic of the sequencer, walker, counters and response register.
   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      head_in        = head_ff;
      active_in      = active_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      space_in       = space_ff;
      exit_in        = exit_ff;
      player_code_in = player_code_ff;
      start_code_in  = start_code_ff;
      status_in      = status_ff;
      moved_in       = moved_ff;
      reached_in     = reached_ff;
      scan_x_in      = scan_x_ff;
      scan_y_in      = scan_y_ff;
      pend_valid_in  = 1'b0;
      pend_x_in      = pend_x_ff;
      pend_y_in      = pend_y_ff;
      start_cnt_in   = start_cnt_ff;
      player_cnt_in  = player_cnt_ff;
      found_x_in     = found_x_ff;
      found_y_in     = found_y_ff;
      ahead_tile_in  = ahead_tile_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_head_in    = rsp_head_ff;
      rsp_moved_in   = rsp_moved_ff;
      rsp_reached_in = rsp_reached_ff;
      rsp_running_in = rsp_running_ff;
      mem_we         = 1'b0;
      mem_waddr      = cell_addr(col_ff, row_ff);
      mem_wdata      = space_ff;
      mem_raddr      = cell_addr(scan_x_ff, scan_y_ff);

      // Configuration writes.
      if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  width_in       = csr_wdata[6:0];
            CSR_GRID_HEIGHT: height_in      = csr_wdata[6:0];
            CSR_SPACE_CODE:  space_in       = csr_wdata;
            CSR_EXIT_CODE:   exit_in        = csr_wdata;
            CSR_PLAYER_CODE: player_code_in = csr_wdata;
            CSR_START_CODE:  start_code_in  = csr_wdata;
            default: begin
            end
         endcase
      end

      // Count start and player tiles as scan reads return, saturating at two.
      if (pend_valid_ff) begin
         if (mem_rdata == start_code_ff && start_cnt_ff != 2'd2) begin
            start_cnt_in = start_cnt_ff + 2'd1;
         end
         if (mem_rdata == player_code_ff) begin
            found_x_in = pend_x_ff;
            found_y_in = pend_y_ff;
            if (player_cnt_ff != 2'd2) begin
               player_cnt_in = player_cnt_ff + 2'd1;
            end
         end
      end

      // The response transaction leaves the output register.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               status_in  = STAT_OK;
               moved_in   = 1'b0;
               reached_in = 1'b0;
               unique case (req_operation)
                  OP_WRITE: begin
                     if ({1'b0, req_cell_x} < cols_used && {1'b0, req_cell_y} < rows_used) begin
                        mem_we    = 1'b1;
                        mem_waddr = cell_addr(req_cell_x, req_cell_y);
                        mem_wdata = req_tile;
                     end else begin
                        status_in = STAT_BAD_COORD;
                     end
                     state_in = S_RESP;
                  end
                  OP_START: begin
                     scan_x_in     = '0;
                     scan_y_in     = '0;
                     start_cnt_in  = '0;
                     player_cnt_in = '0;
                     state_in      = S_SCAN;
                  end
                  OP_STOP: begin
                     active_in = 1'b0;
                     state_in  = S_RESP;
                  end
                  OP_TICK: begin
                     if (active_ff) begin
                        state_in = S_TICK_AHEAD;
                     end else begin
                        status_in = STAT_NOT_RUNNING;
                        state_in  = S_RESP;
                     end
                  end
               endcase
            end
         end

         // One read per cycle, row by row over the grid in use.
         S_SCAN: begin
            pend_valid_in = 1'b1;
            pend_x_in     = scan_x_ff;
            pend_y_in     = scan_y_ff;
            if ({1'b0, scan_x_ff} == cols_used - 7'd1) begin
               scan_x_in = '0;
               if ({1'b0, scan_y_ff} == rows_used - 7'd1) begin
                  state_in = S_SCAN_LAST;
               end else begin
                  scan_y_in = scan_y_ff + 6'd1;
               end
            end else begin
               scan_x_in = scan_x_ff + 6'd1;
            end
         end

         // The last read is counted in this cycle.
         S_SCAN_LAST: begin
            state_in = S_SCAN_FIN;
         end

         S_SCAN_FIN: begin
            if (start_cnt_ff != 2'd1) begin
               status_in = STAT_START_DUP;
            end else begin
               if (player_cnt_ff != 2'd0) begin
                  col_in = found_x_ff;
                  row_in = found_y_ff;
               end
               if (player_cnt_ff != 2'd1) begin
                  status_in = STAT_PLAYER_DUP;
               end else begin
                  active_in = 1'b1;
               end
            end
            state_in = S_RESP;
         end

         S_TICK_AHEAD: begin
            mem_raddr = ahead_in ? cell_addr(ahead_x[5:0], ahead_y[5:0]) : '0;
            state_in  = S_TICK_LEFT;
         end

         S_TICK_LEFT: begin
            ahead_tile_in = mem_rdata;
            mem_raddr     = left_in ? cell_addr(left_x[5:0], left_y[5:0]) : '0;
            state_in      = S_TICK_DECIDE;
         end

         // The left tile is on the read port now. A step clears the old cell.
         S_TICK_DECIDE: begin
            priority if (ahead_in && ahead_tile_ff == exit_ff) begin
               active_in  = 1'b0;
               reached_in = 1'b1;
               state_in   = S_RESP;
            end else if (left_in && mem_rdata == space_ff) begin
               head_in  = left_head;
               col_in   = left_x[5:0];
               row_in   = left_y[5:0];
               moved_in = 1'b1;
               mem_we   = old_in_store;
               state_in = S_TICK_MOVE;
            end else if (ahead_in && ahead_tile_ff == space_ff) begin
               col_in   = ahead_x[5:0];
               row_in   = ahead_y[5:0];
               moved_in = 1'b1;
               mem_we   = old_in_store;
               state_in = S_TICK_MOVE;
            end else begin
               head_in  = head_ff + 2'd3;
               state_in = S_RESP;
            end
         end

         // Mark the walker's new cell.
         S_TICK_MOVE: begin
            mem_we    = 1'b1;
            mem_wdata = player_code_ff;
            state_in  = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_x_in       = col_ff;
               rsp_y_in       = row_ff;
               rsp_head_in    = head_ff;
               rsp_moved_in   = moved_ff;
               rsp_reached_in = reached_ff;
               rsp_running_in = active_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_addr_ff    <= '0;
         col_ff         <= 6'd1;
         row_ff         <= 6'd1;
         head_ff        <= HEAD_RIGHT;
         active_ff      <= 1'b0;
         width_ff       <= RST_GRID_WIDTH;
         height_ff      <= RST_GRID_HEIGHT;
         space_ff       <= RST_SPACE_CODE;
         exit_ff        <= RST_EXIT_CODE;
         player_code_ff <= RST_PLAYER_CODE;
         start_code_ff  <= RST_START_CODE;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         head_ff        <= head_in;
         active_ff      <= active_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         space_ff       <= space_in;
         exit_ff        <= exit_in;
         player_code_ff <= player_code_in;
         start_code_ff  <= start_code_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      moved_ff       <= moved_in;
      reached_ff     <= reached_in;
      scan_x_ff      <= scan_x_in;
      scan_y_ff      <= scan_y_in;
      pend_x_ff      <= pend_x_in;
      pend_y_ff      <= pend_y_in;
      start_cnt_ff   <= start_cnt_in;
      player_cnt_ff  <= player_cnt_in;
      found_x_ff     <= found_x_in;
      found_y_ff     <= found_y_in;
      ahead_tile_ff  <= ahead_tile_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_head_ff    <= rsp_head_in;
      rsp_moved_ff   <= rsp_moved_in;
      rsp_reached_ff <= rsp_reached_in;
      rsp_running_ff <= rsp_running_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_player_x     = rsp_x_ff;
   assign rsp_player_y     = rsp_y_ff;
   assign rsp_heading      = rsp_head_ff;
   assign rsp_moved        = rsp_moved_ff;
   assign rsp_reached_exit = rsp_reached_ff;
   assign rsp_running      = rsp_running_ff;

endmodule
